@@ sv/bnsp_pkg.sv @@
package bnsp_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int MAX_EDGES  = 4096;
	localparam int HEAP_DEPTH = 8192;

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int CNT_W    = 11;
	localparam int EDGE_AW  = $clog2(MAX_EDGES);
	localparam int EDGE_CW  = EDGE_AW + 1;
	localparam int HEAP_AW  = $clog2(HEAP_DEPTH);
	localparam int HEAP_CW  = HEAP_AW + 1;
	localparam int WEIGHT_W = 20;
	localparam int DIST_W   = 48;
	localparam int MODE_W   = 2;

	localparam logic [DIST_W-1:0] DIST_INF = '1;

	localparam logic [MODE_W-1:0] MODE_VIS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0]   a;
		logic [NODE_W-1:0]   b;
		logic [WEIGHT_W-1:0] w;
	} edge_t;

	typedef struct packed {
		logic [DIST_W-1:0] d;
		logic [NODE_W-1:0] n;
	} cand_t;

	localparam int EDGE_W = $bits(edge_t);
	localparam int CAND_W = $bits(cand_t);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CLR, S_EXRD, S_EXLAT, S_EXSIDE, S_EXCHK, S_EXNEXT,
		S_UP, S_UPCMP, S_POP, S_POP0, S_POP1, S_DN, S_DN1, S_DN2, S_DN3,
		S_TOP, S_TOP1, S_FIN
	} state_t;

endpackage

@@ sv/bnsp_ram.sv @@
module bnsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/blocked_node_shortest_path.sv @@
// Channel  | valid        | stall        | payload
// item     | item_valid   | item_stall   | mode, node_a, node_b, weight, visible
// result   | result_valid | result_stall | found, distance
// config   | cfg_we       | (none)       | cfg_wdata (node_count)
//
// Load items are taken while the block is idle. A run first clears the settled flags,
// then for every settled node scans all loaded edges (plus a heap push for each new
// candidate) and pops the heap. The edge scan for each settled node sets the pace.
// After reset, the block clears the visibility flags while item_stall is high.
// Only one item is in work at a time.
module blocked_node_shortest_path (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bnsp_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [bnsp_pkg::MODE_W-1:0]   mode,
	input  logic [bnsp_pkg::NODE_W-1:0]   node_a,
	input  logic [bnsp_pkg::NODE_W-1:0]   node_b,
	input  logic [bnsp_pkg::WEIGHT_W-1:0] weight,
	input  logic                           visible,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           found,
	output logic [bnsp_pkg::DIST_W-1:0]   distance
);
	import bnsp_pkg::*;

	state_t              state_q, state_d;
	logic [NODE_W-1:0]   cnt_q, cnt_d;
	logic [CNT_W-1:0]    node_count_q;
	logic [EDGE_CW-1:0]  edges_q, edges_d;
	logic [EDGE_CW-1:0]  ei_q, ei_d;
	logic [HEAP_CW-1:0]  size_q, size_d;
	logic [HEAP_AW-1:0]  hi_q, hi_d;
	logic [HEAP_AW-1:0]  cidx_q, cidx_d;
	logic                side_q, side_d;
	logic [NODE_W-1:0]   now_q, now_d;
	logic [DIST_W-1:0]   dnow_q, dnow_d;
	edge_t               e_q, e_d;
	cand_t               cand_q, cand_d, top_q, top_d, last_q, last_d, cd_q, cd_d;
	logic                found_q, found_d;
	logic [DIST_W-1:0]   dist_q, dist_d;
	logic                rv_q, rv_d;
	logic                rf_q, rf_d;
	logic [DIST_W-1:0]   rd_q, rd_d;

	logic                vis_we, set_we, set_wdata, vis_wdata, edge_we, heap_we;
	logic [NODE_W-1:0]   vis_waddr, vis_raddr, set_waddr, set_raddr;
	logic                vis_rdata, set_rdata;
	logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
	logic [EDGE_W-1:0]   edge_wdata, edge_rdata;
	logic [HEAP_AW-1:0]  heap_waddr, heap_raddr;
	logic [CAND_W-1:0]   heap_wdata, heap_rdata;

	logic [CNT_W-1:0]    target;
	logic                accept;
	logic                match;
	logic [NODE_W-1:0]   other;
	logic [DIST_W:0]     sum;
	logic [HEAP_AW+1:0]  child;
	cand_t               hrd;
	logic [HEAP_CW-1:0]  size_m1;

	bnsp_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rdata)
	);
	bnsp_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_set (
		.clk(clk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
		.raddr(set_raddr), .rdata(set_rdata)
	);
	bnsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);
	bnsp_ram #(.WIDTH(CAND_W), .DEPTH(HEAP_DEPTH)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	assign target       = node_count_q - CNT_W'(1);
	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = rv_q;
	assign found        = rf_q;
	assign distance     = rd_q;
	assign hrd          = cand_t'(heap_rdata);
	assign other        = side_q ? e_q.a : e_q.b;
	assign match        = (side_q ? e_q.b : e_q.a) == now_q;
	assign sum          = {1'b0, dnow_q} + (DIST_W+1)'(e_q.w);
	assign child        = {1'b0, hi_q, 1'b1};
	assign size_m1      = size_q - HEAP_CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(2);
		end else if (cfg_we) begin
			if (cfg_wdata < CNT_W'(2)) begin
				node_count_q <= CNT_W'(2);
			end else if (cfg_wdata > CNT_W'(MAX_NODES)) begin
				node_count_q <= CNT_W'(MAX_NODES);
			end else begin
				node_count_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			edges_q <= '0;
			ei_q    <= '0;
			size_q  <= '0;
			side_q  <= 1'b0;
			found_q <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			edges_q <= edges_d;
			ei_q    <= ei_d;
			size_q  <= size_d;
			side_q  <= side_d;
			found_q <= found_d;
			rv_q    <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_q   <= hi_d;
		cidx_q <= cidx_d;
		now_q  <= now_d;
		dnow_q <= dnow_d;
		e_q    <= e_d;
		cand_q <= cand_d;
		top_q  <= top_d;
		last_q <= last_d;
		cd_q   <= cd_d;
		dist_q <= dist_d;
		rf_q   <= rf_d;
		rd_q   <= rd_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		edges_d = edges_q;
		ei_d    = ei_q;
		size_d  = size_q;
		hi_d    = hi_q;
		cidx_d  = cidx_q;
		side_d  = side_q;
		now_d   = now_q;
		dnow_d  = dnow_q;
		e_d     = e_q;
		cand_d  = cand_q;
		top_d   = top_q;
		last_d  = last_q;
		cd_d    = cd_q;
		found_d = found_q;
		dist_d  = dist_q;
		rv_d    = rv_q && result_stall;
		rf_d    = rf_q;
		rd_d    = rd_q;

		vis_we = 1'b0; vis_waddr = '0; vis_wdata = 1'b0; vis_raddr = other;
		set_we = 1'b0; set_waddr = '0; set_wdata = 1'b0; set_raddr = other;
		edge_we = 1'b0; edge_waddr = edges_q[EDGE_AW-1:0];
		edge_wdata = {node_a, node_b, weight};
		edge_raddr = ei_q[EDGE_AW-1:0];
		heap_we = 1'b0; heap_waddr = hi_q; heap_wdata = cand_q; heap_raddr = '0;

		case (state_q)
			S_INIT: begin
				vis_we    = 1'b1;
				vis_waddr = cnt_q;
				cnt_d     = cnt_q + NODE_W'(1);
				if (cnt_q == NODE_W'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_VIS: begin
							vis_we    = 1'b1;
							vis_waddr = node_a;
							vis_wdata = visible;
						end
						MODE_EDGE: begin
							if (edges_q < EDGE_CW'(MAX_EDGES)) begin
								edge_we = 1'b1;
								edges_d = edges_q + EDGE_CW'(1);
							end
						end
						MODE_RUN: begin
							cnt_d   = '0;
							state_d = S_CLR;
						end
						default: ;
					endcase
				end
			end
			S_CLR: begin
				// Node 0 is the start and is settled from the outset.
				set_we    = 1'b1;
				set_waddr = cnt_q;
				set_wdata = (cnt_q == '0);
				cnt_d     = cnt_q + NODE_W'(1);
				if (cnt_q == NODE_W'(MAX_NODES - 1)) begin
					size_d  = '0;
					found_d = 1'b0;
					dist_d  = '0;
					now_d   = '0;
					dnow_d  = '0;
					ei_d    = '0;
					state_d = S_EXRD;
				end
			end
			S_EXRD: begin
				if (ei_q == edges_q) begin
					state_d = S_POP;
				end else begin
					side_d  = 1'b0;
					state_d = S_EXLAT;
				end
			end
			S_EXLAT: begin
				e_d     = edge_t'(edge_rdata);
				state_d = S_EXSIDE;
			end
			S_EXSIDE: begin
				if (match && ({1'b0, other} < node_count_q)) begin
					state_d = S_EXCHK;
				end else begin
					state_d = S_EXNEXT;
				end
			end
			S_EXCHK: begin
				state_d = S_EXNEXT;
				if (!set_rdata && (({1'b0, other} == target) || !vis_rdata)) begin
					if (size_q < HEAP_CW'(HEAP_DEPTH)) begin
						cand_d.d = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
						cand_d.n = other;
						hi_d     = size_q[HEAP_AW-1:0];
						size_d   = size_q + HEAP_CW'(1);
						state_d  = S_UP;
					end
				end
			end
			S_EXNEXT: begin
				if (!side_q) begin
					side_d  = 1'b1;
					state_d = S_EXSIDE;
				end else begin
					ei_d    = ei_q + EDGE_CW'(1);
					state_d = S_EXRD;
				end
			end
			S_UP: begin
				if (hi_q == '0) begin
					heap_we = 1'b1;
					state_d = S_EXNEXT;
				end else begin
					cidx_d     = (hi_q - HEAP_AW'(1)) >> 1;
					heap_raddr = (hi_q - HEAP_AW'(1)) >> 1;
					state_d    = S_UPCMP;
				end
			end
			S_UPCMP: begin
				heap_we = 1'b1;
				if (hrd.d <= cand_q.d) begin
					state_d = S_EXNEXT;
				end else begin
					heap_wdata = heap_rdata;
					hi_d       = cidx_q;
					state_d    = S_UP;
				end
			end
			S_POP: begin
				heap_raddr = '0;
				if (size_q == '0) begin
					state_d = S_FIN;
				end else begin
					state_d = S_POP0;
				end
			end
			S_POP0: begin
				top_d      = hrd;
				size_d     = size_m1;
				heap_raddr = size_m1[HEAP_AW-1:0];
				if (size_m1 == '0) begin
					state_d = S_TOP;
				end else begin
					state_d = S_POP1;
				end
			end
			S_POP1: begin
				last_d  = hrd;
				hi_d    = '0;
				state_d = S_DN;
			end
			S_DN: begin
				if (child >= (HEAP_AW+2)'(size_q)) begin
					heap_we    = 1'b1;
					heap_wdata = last_q;
					state_d    = S_TOP;
				end else begin
					heap_raddr = child[HEAP_AW-1:0];
					cidx_d     = child[HEAP_AW-1:0];
					state_d    = S_DN1;
				end
			end
			S_DN1: begin
				cd_d       = hrd;
				heap_raddr = cidx_q + HEAP_AW'(1);
				if ((HEAP_CW'(cidx_q) + HEAP_CW'(1)) < size_q) begin
					state_d = S_DN2;
				end else begin
					state_d = S_DN3;
				end
			end
			S_DN2: begin
				if (hrd.d < cd_q.d) begin
					cd_d   = hrd;
					cidx_d = cidx_q + HEAP_AW'(1);
				end
				state_d = S_DN3;
			end
			S_DN3: begin
				heap_we = 1'b1;
				if (cd_q.d >= last_q.d) begin
					heap_wdata = last_q;
					state_d    = S_TOP;
				end else begin
					heap_wdata = cd_q;
					hi_d       = cidx_q;
					state_d    = S_DN;
				end
			end
			S_TOP: begin
				set_raddr = top_q.n;
				state_d   = S_TOP1;
			end
			S_TOP1: begin
				if (set_rdata) begin
					state_d = S_POP;
				end else begin
					set_we    = 1'b1;
					set_waddr = top_q.n;
					set_wdata = 1'b1;
					if ({1'b0, top_q.n} == target) begin
						found_d = 1'b1;
						dist_d  = top_q.d;
					end
					now_d   = top_q.n;
					dnow_d  = top_q.d;
					ei_d    = '0;
					state_d = S_EXRD;
				end
			end
			S_FIN: begin
				// Hold the result until the output register is free.
				if (!rv_d) begin
					rv_d    = 1'b1;
					rf_d    = found_q;
					rd_d    = found_q ? dist_q : '0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
